[hw/rtl/lps_pkg.sv]
// Shared constants, register codes, control structs and helpers for the lane peak steering core.
package lps_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COUNT_BITS = 8;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int LEN_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_BITS  = 12;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int PEAK_COL_BITS = 11;
  localparam int CNT_OUT_BITS  = 8;
  localparam int OFFSET_BITS   = 12;
  localparam int CMD_BITS      = 16;

  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 48;

  // steering arithmetic
  localparam int R_BITS       = 15;
  localparam int NUMER_BITS   = 12;
  localparam int SPAN_BITS    = 16;
  localparam int PROD_BITS    = NUMER_BITS + SPAN_BITS;
  localparam int DIVISOR_BITS = 12;
  localparam int FIN_BITS     = PROD_BITS + 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_BAND_TOP       = 3'd1,
    REG_BAND_ROWS      = 3'd2,
    REG_CENTER_COLUMN  = 3'd3,
    REG_LINE_TO_CENTER = 3'd4,
    REG_HALF_RANGE     = 3'd5,
    REG_CMD_MIN        = 3'd6,
    REG_CMD_MAX        = 3'd7
  } reg_idx_e;

  localparam logic [11:0] FRAME_WIDTH_RST    = 12'd1280;
  localparam logic [11:0] BAND_TOP_RST       = 12'd200;
  localparam logic [7:0]  BAND_ROWS_RST      = 8'd50;
  localparam logic [11:0] CENTER_COLUMN_RST  = 12'd520;
  localparam logic [11:0] LINE_TO_CENTER_RST = 12'd400;
  localparam logic [10:0] HALF_RANGE_RST     = 11'd350;
  localparam logic [15:0] CMD_MIN_RST        = 16'd1201;
  localparam logic [15:0] CMD_MAX_RST        = 16'd1400;

  typedef struct packed {
    logic pix_accept;
    logic pix_last;
    logic inc_write;
    logic sweep;
    logic scan;
    logic calc_offset;
    logic calc_mul;
    logic div_start;
    logic calc_final;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic sweep_last;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    if (c == COUNT_MAX) begin
      return c;
    end
    return c + COUNT_BITS'(1);
  endfunction

  function automatic logic [CNT_OUT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > ((32'd1 << CNT_OUT_BITS) - 32'd1)) begin
      return {CNT_OUT_BITS{1'b1}};
    end
    return CNT_OUT_BITS'(wide);
  endfunction

endpackage

[hw/rtl/lps_div.sv]
// Restoring divider, one quotient bit per cycle, for the steering map.
module lps_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lps_pkg::PROD_BITS-1:0]       dividend_i,
  input  logic [lps_pkg::DIVISOR_BITS-1:0]    divisor_i,
  output logic                                done_o,
  output logic [lps_pkg::PROD_BITS-1:0]       quotient_o
);

  localparam int CNT_W = $clog2(lps_pkg::PROD_BITS);

  logic                                busy_q;
  logic                                done_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic [lps_pkg::DIVISOR_BITS-1:0]    rem_q;
  logic [lps_pkg::DIVISOR_BITS-1:0]    dsr_q;
  logic [lps_pkg::PROD_BITS-1:0]       quo_q;

  logic [lps_pkg::DIVISOR_BITS:0]      trial;
  logic                                fits;

  assign trial = {rem_q, quo_q[lps_pkg::PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(lps_pkg::PROD_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (fits) begin
        rem_q <= lps_pkg::DIVISOR_BITS'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[lps_pkg::DIVISOR_BITS-1:0];
      end
      quo_q <= {quo_q[lps_pkg::PROD_BITS-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

[hw/rtl/lps_datapath.sv]
// Datapath: registers, position counters, column histogram, peak scan, steering math, output.
module lps_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_BITS-1:0]       cfg_addr_i,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  logic                                   lit_i,
  input  lps_pkg::cmd_t                          cmd_i,
  output lps_pkg::status_t                       status_o,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [lps_pkg::OUT_TDATA_BITS-1:0]     out_data_o
);

  // configuration
  logic [11:0] frame_width_q;
  logic [11:0] band_top_q;
  logic [7:0]  band_rows_q;
  logic [11:0] center_column_q;
  logic [11:0] line_to_center_q;
  logic [10:0] half_range_q;
  logic [15:0] cmd_min_q;
  logic [15:0] cmd_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= lps_pkg::FRAME_WIDTH_RST;
      band_top_q       <= lps_pkg::BAND_TOP_RST;
      band_rows_q      <= lps_pkg::BAND_ROWS_RST;
      center_column_q  <= lps_pkg::CENTER_COLUMN_RST;
      line_to_center_q <= lps_pkg::LINE_TO_CENTER_RST;
      half_range_q     <= lps_pkg::HALF_RANGE_RST;
      cmd_min_q        <= lps_pkg::CMD_MIN_RST;
      cmd_max_q        <= lps_pkg::CMD_MAX_RST;
    end else if (cfg_we_i) begin
      case (lps_pkg::reg_idx_e'(cfg_addr_i))
        lps_pkg::REG_FRAME_WIDTH:    frame_width_q    <= cfg_wdata_i[11:0];
        lps_pkg::REG_BAND_TOP:       band_top_q       <= cfg_wdata_i[11:0];
        lps_pkg::REG_BAND_ROWS:      band_rows_q      <= cfg_wdata_i[7:0];
        lps_pkg::REG_CENTER_COLUMN:  center_column_q  <= cfg_wdata_i[11:0];
        lps_pkg::REG_LINE_TO_CENTER: line_to_center_q <= cfg_wdata_i[11:0];
        lps_pkg::REG_HALF_RANGE:     half_range_q     <= cfg_wdata_i[10:0];
        lps_pkg::REG_CMD_MIN:        cmd_min_q        <= cfg_wdata_i;
        lps_pkg::REG_CMD_MAX:        cmd_max_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // row length, clamped to one..MAX_WIDTH
  logic [lps_pkg::LEN_BITS-1:0] w_len;

  always_comb begin
    if (frame_width_q == 12'd0) begin
      w_len = lps_pkg::LEN_BITS'(1);
    end else if (32'(frame_width_q) > lps_pkg::MAX_WIDTH) begin
      w_len = lps_pkg::LEN_BITS'(lps_pkg::MAX_WIDTH);
    end else begin
      w_len = lps_pkg::LEN_BITS'(frame_width_q);
    end
  end

  // pixel position
  logic [lps_pkg::COL_BITS-1:0] col_q, col_d, col_eff;
  logic [lps_pkg::ROW_BITS-1:0] row_q, row_d;
  logic [lps_pkg::LEN_BITS-1:0] col_next;
  logic                         in_band;

  always_comb begin
    if (lps_pkg::LEN_BITS'(col_q) >= w_len) begin
      col_eff = lps_pkg::COL_BITS'(w_len - lps_pkg::LEN_BITS'(1));
    end else begin
      col_eff = col_q;
    end
    col_next = lps_pkg::LEN_BITS'(col_eff) + lps_pkg::LEN_BITS'(1);
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.pix_accept) begin
      if (cmd_i.pix_last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_next >= w_len) begin
        col_d = '0;
        row_d = row_q + lps_pkg::ROW_BITS'(1);
      end else begin
        col_d = lps_pkg::COL_BITS'(col_next);
      end
    end
  end

  assign in_band = (row_q >= band_top_q) &&
                   ((row_q - band_top_q) < lps_pkg::ROW_BITS'(band_rows_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // histogram memory, read-modify-write: read registered in rd_q, increment written back at inc_addr_q
  logic [lps_pkg::COUNT_BITS-1:0] hist_mem_q [lps_pkg::MAX_WIDTH];
  logic [lps_pkg::COUNT_BITS-1:0] rd_q;
  logic [lps_pkg::COL_BITS-1:0]   inc_addr_q;
  logic [lps_pkg::COL_BITS-1:0]   sweep_q;
  logic [lps_pkg::COL_BITS-1:0]   mem_raddr, mem_waddr;
  logic [lps_pkg::COUNT_BITS-1:0] mem_wdata;
  logic                           mem_we;
  logic                           sweep_last;

  assign sweep_last = (32'(sweep_q) == lps_pkg::MAX_WIDTH - 1);
  assign mem_raddr  = cmd_i.sweep ? sweep_q : col_eff;
  assign mem_waddr  = cmd_i.sweep ? sweep_q : inc_addr_q;
  assign mem_wdata  = cmd_i.sweep ? '0 : lps_pkg::sat_inc(rd_q);
  assign mem_we     = cmd_i.sweep | cmd_i.inc_write;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= hist_mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept) begin
      inc_addr_q <= col_eff;
    end
  end

  // sweep reads every entry and clears it behind the read
  logic                         cmp_v_q;
  logic [lps_pkg::COL_BITS-1:0] cmp_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      if (cmd_i.sweep) begin
        sweep_q <= sweep_last ? '0 : sweep_q + lps_pkg::COL_BITS'(1);
      end
      cmp_v_q <= cmd_i.scan && (lps_pkg::LEN_BITS'(sweep_q) < w_len);
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q <= sweep_q;
  end

  // running peak, first column wins ties
  logic [lps_pkg::COUNT_BITS-1:0] best_q;
  logic [lps_pkg::COL_BITS-1:0]   best_col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_last) begin
      best_q     <= '0;
      best_col_q <= '0;
    end else if (cmp_v_q && (rd_q > best_q)) begin
      best_q     <= rd_q;
      best_col_q <= cmp_addr_q;
    end
  end

  // offset and map operands
  logic signed [lps_pkg::R_BITS-1:0]    r_raw, h_s, r_clamp;
  logic signed [lps_pkg::SPAN_BITS:0]   span_w, span_abs;
  logic signed [lps_pkg::OFFSET_BITS-1:0] offset_q;
  logic [lps_pkg::NUMER_BITS-1:0]       numer_q;
  logic [lps_pkg::SPAN_BITS-1:0]        span_mag_q;
  logic                                 span_neg_q;

  always_comb begin
    h_s   = $signed(lps_pkg::R_BITS'(half_range_q));
    r_raw = $signed(lps_pkg::R_BITS'(best_col_q)) + $signed(lps_pkg::R_BITS'(line_to_center_q))
            - $signed(lps_pkg::R_BITS'(center_column_q));
    if (r_raw > h_s) begin
      r_clamp = h_s;
    end else if (r_raw < -h_s) begin
      r_clamp = -h_s;
    end else begin
      r_clamp = r_raw;
    end
    span_w   = $signed({1'b0, cmd_max_q}) - $signed({1'b0, cmd_min_q});
    span_abs = span_w[lps_pkg::SPAN_BITS] ? -span_w : span_w;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_offset) begin
      offset_q   <= lps_pkg::OFFSET_BITS'(r_clamp);
      numer_q    <= lps_pkg::NUMER_BITS'(r_clamp + h_s);
      span_neg_q <= span_w[lps_pkg::SPAN_BITS];
      span_mag_q <= span_abs[lps_pkg::SPAN_BITS-1:0];
    end
  end

  logic [lps_pkg::PROD_BITS-1:0]    prod_q;
  logic [lps_pkg::PROD_BITS-1:0]    prod_w;
  logic [lps_pkg::PROD_BITS-1:0]    quot;
  logic                             div_done;

  assign prod_w = lps_pkg::PROD_BITS'(numer_q) * lps_pkg::PROD_BITS'(span_mag_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_mul) begin
      prod_q <= prod_w;
    end
  end

  lps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  ({half_range_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // apply sign, add base, clamp low then high
  logic signed [lps_pkg::FIN_BITS-1:0] mag_s, min_s, max_s, cmd_w;
  logic [lps_pkg::CMD_BITS-1:0]        steer_q;

  always_comb begin
    mag_s = $signed(lps_pkg::FIN_BITS'(quot));
    min_s = $signed(lps_pkg::FIN_BITS'(cmd_min_q));
    max_s = $signed(lps_pkg::FIN_BITS'(cmd_max_q));
    cmd_w = (span_neg_q ? -mag_s : mag_s) + min_s;
    if (half_range_q == 11'd0) begin
      cmd_w = min_s;
    end
    if (cmd_w < min_s) begin
      cmd_w = min_s;
    end
    if (cmd_w > max_s) begin
      cmd_w = max_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_final) begin
      steer_q <= lps_pkg::CMD_BITS'(cmd_w);
    end
  end

  // output register
  logic                                out_valid_q;
  logic [lps_pkg::OUT_TDATA_BITS-1:0]  out_data_q;
  logic [lps_pkg::PEAK_COL_BITS-1:0]   peak_col;

  assign peak_col = lps_pkg::PEAK_COL_BITS'(best_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= lps_pkg::OUT_TDATA_BITS'({steer_q, offset_q,
                                             lps_pkg::sat_count(best_q), peak_col});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.hit        = lit_i & in_band;
  assign status_o.sweep_last = sweep_last;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q | out_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_peak_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.calc_offset |-> (lps_pkg::LEN_BITS'(best_col_q) < w_len))
    else $error("peak column outside the row");

  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.inc_write && cmd_i.sweep))
    else $error("histogram increment during sweep");

endmodule

[hw/rtl/lps_ctrl.sv]
// Controller: sequences pixel updates, histogram sweeps and the steering computation.
module lps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tlast_i,
  output logic               s_tready_o,
  input  lps_pkg::status_t   status_i,
  output lps_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_INC_END,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_OFFSET,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINAL,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          if (status_i.hit) begin
            state_d = s_tlast_i ? ST_INC_END : ST_INC;
          end else if (s_tlast_i) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_INC:       state_d = ST_IDLE;
      ST_INC_END:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.sweep_last) state_d = ST_SCAN_TAIL;
      end
      ST_SCAN_TAIL: state_d = ST_OFFSET;
      ST_OFFSET:    state_d = ST_MUL;
      ST_MUL:       state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status_i.div_done) state_d = ST_FINAL;
      end
      ST_FINAL:     state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o             = '0;
    cmd_o.pix_accept  = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.pix_last    = (state_q == ST_IDLE) && s_tvalid_i && s_tlast_i;
    cmd_o.inc_write   = (state_q == ST_INC) || (state_q == ST_INC_END);
    cmd_o.sweep       = (state_q == ST_CLEAR) || (state_q == ST_SCAN);
    cmd_o.scan        = (state_q == ST_SCAN);
    cmd_o.calc_offset = (state_q == ST_OFFSET);
    cmd_o.calc_mul    = (state_q == ST_MUL);
    cmd_o.div_start   = (state_q == ST_DIV_START);
    cmd_o.calc_final  = (state_q == ST_FINAL);
    cmd_o.out_load    = (state_q == ST_EMIT) && status_i.out_free;
  end

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

endmodule

[hw/rtl/lane_peak_steering_core.sv]
// Top level of the lane peak steering core: stream ports, config port, controller and datapath.
//
// Input stream: one binary pixel per beat in raster order, tdata[0] is the pixel,
// tlast marks the last pixel of the frame. Output stream: one beat per frame with the peak
// column, its count, the clamped offset and the steering command. Registers are to be written
// through cfg_we_i/cfg_addr_i/cfg_wdata_i while the core is idle; this is not enforced.
//
// Pixel flow: a pixel outside the band or unlit is taken in the idle state alone; a lit pixel
// inside the band adds an increment state, tready low, for the histogram read-modify-write.
// After the tlast beat the core sweeps all MAX_WIDTH histogram entries (one per cycle,
// finding the peak and clearing behind it), then maps the offset through a multiplier
// and a one-bit-per-cycle divider and loads the result into the output register;
// tready stays low until the controller returns to idle.
// Reset: a clearing pass over all MAX_WIDTH histogram entries holds tready low;
// config writes are taken meanwhile. Registers return to their defaults.
// Stall: a result waits in the output register while pixels of the next frame are
// accepted; the next frame's result holds in the core until that beat is taken.
module lane_peak_steering_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lps_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,  // [0] lit, [7:1] zero
  input  logic                                 s_axis_tlast,  // frame_end
  // stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [10:0] peak_column, [18:11] peak_count, [30:19] offset, [46:31] steer_cmd, [47] zero
  output logic [lps_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_BITS-1:0]     cfg_addr_i,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i
);

  lps_pkg::cmd_t    cmd;
  lps_pkg::status_t status;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lit_i       (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
